// ===== hw/rtl/dllp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and helpers for the doubly linked list pool.
// No dependencies; used by the channel interfaces and the top level.
package dllp_pkg;

    localparam int CAPACITY  = 1024;
    localparam int SLOTS     = CAPACITY + 1;          // slot 0 is the sentinel
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int OPCODE_W  = 3;
    localparam int LINK_W    = 11;
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 11;
    localparam int STATUS_W  = 2;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD       = 3'd0,
        OP_START      = 3'd1,
        OP_REMOVE     = 3'd2,
        OP_INS_AFTER  = 3'd3,
        OP_INS_BEFORE = 3'd4,
        OP_WALK       = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_SENTINEL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LINK,
        S_WALK2,
        S_EMIT
    } state_t;

    // Port index (-1 = sentinel, out of range also maps to sentinel) to slot.
    function automatic slot_t to_slot(logic [LINK_W-1:0] raw);
        logic [31:0] u;
        u = 32'(raw);
        if (!raw[LINK_W-1] && (u < 32'(CAPACITY)))
            to_slot = SLOT_W'(u + 32'd1);
        else
            to_slot = '0;
    endfunction

    // Saturate the count given with start.
    function automatic slot_t sat_count(logic [COUNT_W-1:0] c);
        if (32'(c) > 32'(CAPACITY))
            sat_count = SLOT_W'(CAPACITY);
        else
            sat_count = SLOT_W'(c);
    endfunction

endpackage

// ===== hw/rtl/dllp_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the list pool: request and response.
// Depends on dllp_pkg for field widths.
interface dllp_req_if;
    logic                            valid;
    logic                            ready;
    logic [dllp_pkg::OPCODE_W-1:0]   opcode;
    logic signed [dllp_pkg::LINK_W-1:0] index;
    logic signed [dllp_pkg::DATA_W-1:0] value;
    logic signed [dllp_pkg::LINK_W-1:0] next_link;
    logic signed [dllp_pkg::LINK_W-1:0] prev_link;
    logic [dllp_pkg::COUNT_W-1:0]    node_count;

    modport source (output valid, opcode, index, value, next_link, prev_link, node_count,
                    input ready);
    modport sink   (input valid, opcode, index, value, next_link, prev_link, node_count,
                    output ready);
endinterface

interface dllp_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [dllp_pkg::DATA_W-1:0] result_value;
    logic [dllp_pkg::IDX_W-1:0]         new_index;
    logic                               walk_last;
    logic                               list_empty;
    logic [dllp_pkg::STATUS_W-1:0]      status;

    modport source (output valid, result_value, new_index, walk_last, list_empty, status,
                    input ready);
    modport sink   (input valid, result_value, new_index, walk_last, list_empty, status,
                    output ready);
endinterface

// ===== hw/rtl/doubly_linked_list_pool.sv =====
`timescale 1ns / 1ps
// Doubly linked list pool: node values and links held in three RAMs.
// Depends on dllp_pkg and the channel interfaces in dllp_if.sv.
//
// Usage
//   req: one request per operation (load, start, remove, insert after,
//        insert before, walk), valid/ready; accepted when both are high.
//   rsp: one response for remove, insert and walk; none for load, start or
//        an unknown opcode. The response sits in an output register, so the
//        block finishes reads and first-stage writes while it waits.
//   Steps per request: load, start and an unknown opcode finish in S_IDLE;
//   remove, pool full, sentinel and a walk of an empty list pass S_READ or
//   S_EMIT; insert after/before passes S_READ then S_LINK, and a walk step
//   S_READ then S_WALK2. Set by the RAMs: each has one read port with a
//   registered read and one write port, and an insert writes two entries of
//   each link RAM, so it writes in both S_READ and S_LINK after its read.
//   Reset (rst_n low, asynchronous) clears the pool count, walk cursor, sequencer
//   and response valid; RAMs are not cleared, so load/start entries before reading.
//   When rsp.ready is low with a response pending, the next response-making
//   request waits in its final step; reads already done are held.
module doubly_linked_list_pool (
    input  logic       clk,
    input  logic       rst_n,
    dllp_req_if.sink   req,
    dllp_rsp_if.source rsp
);

    // ------------------------------------------------------------------
    // Pool RAMs
    // ------------------------------------------------------------------
    dllp_pkg::slot_t             next_mem [dllp_pkg::SLOTS];
    dllp_pkg::slot_t             prev_mem [dllp_pkg::SLOTS];
    logic [dllp_pkg::DATA_W-1:0] val_mem  [dllp_pkg::SLOTS];

    logic                        nx_we, nx_re;
    dllp_pkg::slot_t             nx_waddr, nx_wdata, nx_raddr, nx_q;
    logic                        pv_we, pv_re;
    dllp_pkg::slot_t             pv_waddr, pv_wdata, pv_raddr, pv_q;
    logic                        vl_we, vl_re;
    dllp_pkg::slot_t             vl_waddr, vl_raddr;
    logic [dllp_pkg::DATA_W-1:0] vl_wdata, vl_q;

    always_ff @(posedge clk)
    begin
        if (nx_we)
            next_mem[nx_waddr] <= nx_wdata;
        if (nx_re)
            nx_q <= next_mem[nx_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pv_we)
            prev_mem[pv_waddr] <= pv_wdata;
        if (pv_re)
            pv_q <= prev_mem[pv_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (vl_we)
            val_mem[vl_waddr] <= vl_wdata;
        if (vl_re)
            vl_q <= val_mem[vl_raddr];
    end

    // ------------------------------------------------------------------
    // Control and request holding registers
    // ------------------------------------------------------------------
    dllp_pkg::state_t            state_reg, state_next;
    dllp_pkg::slot_t             alloc_count_reg, alloc_count_next;
    dllp_pkg::slot_t             cursor_reg, cursor_next;
    dllp_pkg::op_t               op_reg, op_next;
    dllp_pkg::slot_t             tgt_reg, tgt_next;
    logic [dllp_pkg::DATA_W-1:0] value_reg, value_next;
    dllp_pkg::slot_t             node_reg, node_next;
    dllp_pkg::status_t           err_reg, err_next;

    // Response register
    logic                        out_valid_reg;
    logic [dllp_pkg::DATA_W-1:0] result_value_reg;
    logic [dllp_pkg::IDX_W-1:0]  new_index_reg;
    logic                        walk_last_reg;
    logic                        list_empty_reg;
    dllp_pkg::status_t           status_reg;

    // Response staging from the sequencer
    logic                        emit;
    logic [dllp_pkg::DATA_W-1:0] emit_value;
    logic [dllp_pkg::IDX_W-1:0]  emit_index;
    logic                        emit_last;
    logic                        emit_empty;
    dllp_pkg::status_t           emit_status;

    logic                        can_emit;
    logic                        accept;
    dllp_pkg::slot_t             req_tgt;
    dllp_pkg::slot_t             new_slot;

    assign req.ready = (state_reg == dllp_pkg::S_IDLE);
    assign accept    = req.valid && req.ready;
    assign req_tgt   = dllp_pkg::to_slot(req.index);
    // Slot an insert claims; only used while alloc_count < CAPACITY.
    assign new_slot  = alloc_count_reg + dllp_pkg::SLOT_W'(1);
    // The response register is free now or frees at this edge.
    assign can_emit  = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= dllp_pkg::S_IDLE;
            alloc_count_reg <= '0;
            cursor_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            alloc_count_reg <= alloc_count_next;
            cursor_reg      <= cursor_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        tgt_reg   <= tgt_next;
        value_reg <= value_next;
        node_reg  <= node_next;
        err_reg   <= err_next;
        if (emit)
        begin
            result_value_reg <= emit_value;
            new_index_reg    <= emit_index;
            walk_last_reg    <= emit_last;
            list_empty_reg   <= emit_empty;
            status_reg       <= emit_status;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: read the target, then write back the links
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        alloc_count_next = alloc_count_reg;
        cursor_next      = cursor_reg;
        op_next          = op_reg;
        tgt_next         = tgt_reg;
        value_next       = value_reg;
        node_next        = node_reg;
        err_next         = err_reg;

        nx_we = 1'b0;  nx_waddr = '0;  nx_wdata = '0;  nx_re = 1'b0;  nx_raddr = '0;
        pv_we = 1'b0;  pv_waddr = '0;  pv_wdata = '0;  pv_re = 1'b0;  pv_raddr = '0;
        vl_we = 1'b0;  vl_waddr = '0;  vl_wdata = '0;  vl_re = 1'b0;  vl_raddr = '0;

        emit        = 1'b0;
        emit_value  = '0;
        emit_index  = '0;
        emit_last   = 1'b0;
        emit_empty  = 1'b0;
        emit_status = dllp_pkg::ST_OK;

        case (state_reg)
            dllp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = dllp_pkg::op_t'(req.opcode);
                    tgt_next   = req_tgt;
                    value_next = req.value;
                    case (req.opcode)
                        dllp_pkg::OP_LOAD:
                        begin
                            cursor_next = '0;
                            if (req_tgt != '0)
                            begin
                                vl_we    = 1'b1;
                                vl_waddr = req_tgt;
                                vl_wdata = req.value;
                                nx_we    = 1'b1;
                                nx_waddr = req_tgt;
                                nx_wdata = dllp_pkg::to_slot(req.next_link);
                                pv_we    = 1'b1;
                                pv_waddr = req_tgt;
                                pv_wdata = dllp_pkg::to_slot(req.prev_link);
                            end
                        end
                        dllp_pkg::OP_START:
                        begin
                            cursor_next      = '0;
                            nx_we            = 1'b1;
                            nx_waddr         = '0;
                            nx_wdata         = dllp_pkg::to_slot(req.next_link);
                            pv_we            = 1'b1;
                            pv_waddr         = '0;
                            pv_wdata         = dllp_pkg::to_slot(req.prev_link);
                            alloc_count_next = dllp_pkg::sat_count(req.node_count);
                        end
                        dllp_pkg::OP_REMOVE:
                        begin
                            cursor_next = '0;
                            if (req_tgt == '0)
                            begin
                                err_next   = dllp_pkg::ST_SENTINEL;
                                state_next = dllp_pkg::S_EMIT;
                            end
                            else
                            begin
                                nx_re      = 1'b1;
                                nx_raddr   = req_tgt;
                                pv_re      = 1'b1;
                                pv_raddr   = req_tgt;
                                vl_re      = 1'b1;
                                vl_raddr   = req_tgt;
                                state_next = dllp_pkg::S_READ;
                            end
                        end
                        dllp_pkg::OP_INS_AFTER, dllp_pkg::OP_INS_BEFORE:
                        begin
                            cursor_next = '0;
                            if (32'(alloc_count_reg) >= 32'(dllp_pkg::CAPACITY))
                            begin
                                err_next   = dllp_pkg::ST_FULL;
                                state_next = dllp_pkg::S_EMIT;
                            end
                            else
                            begin
                                nx_re      = 1'b1;
                                nx_raddr   = req_tgt;
                                pv_re      = 1'b1;
                                pv_raddr   = req_tgt;
                                state_next = dllp_pkg::S_READ;
                            end
                        end
                        dllp_pkg::OP_WALK:
                        begin
                            nx_re      = 1'b1;
                            nx_raddr   = cursor_reg;
                            state_next = dllp_pkg::S_READ;
                        end
                        default:
                        begin
                            // unknown opcode: dropped, cursor kept
                        end
                    endcase
                end
            end

            dllp_pkg::S_READ:
            begin
                case (op_reg)
                    dllp_pkg::OP_REMOVE:
                    begin
                        if (can_emit)
                        begin
                            pv_we      = 1'b1;
                            pv_waddr   = nx_q;
                            pv_wdata   = pv_q;
                            nx_we      = 1'b1;
                            nx_waddr   = pv_q;
                            nx_wdata   = nx_q;
                            emit       = 1'b1;
                            emit_value = vl_q;
                            state_next = dllp_pkg::S_IDLE;
                        end
                    end
                    dllp_pkg::OP_INS_AFTER:
                    begin
                        // new node first; the neighbors follow in S_LINK
                        nx_we      = 1'b1;
                        nx_waddr   = new_slot;
                        nx_wdata   = nx_q;
                        pv_we      = 1'b1;
                        pv_waddr   = new_slot;
                        pv_wdata   = tgt_reg;
                        vl_we      = 1'b1;
                        vl_waddr   = new_slot;
                        vl_wdata   = value_reg;
                        state_next = dllp_pkg::S_LINK;
                    end
                    dllp_pkg::OP_INS_BEFORE:
                    begin
                        nx_we      = 1'b1;
                        nx_waddr   = new_slot;
                        nx_wdata   = tgt_reg;
                        pv_we      = 1'b1;
                        pv_waddr   = new_slot;
                        pv_wdata   = pv_q;
                        vl_we      = 1'b1;
                        vl_waddr   = new_slot;
                        vl_wdata   = value_reg;
                        state_next = dllp_pkg::S_LINK;
                    end
                    dllp_pkg::OP_WALK:
                    begin
                        if (nx_q == '0)
                        begin
                            if (can_emit)
                            begin
                                emit        = 1'b1;
                                emit_empty  = 1'b1;
                                cursor_next = '0;
                                state_next  = dllp_pkg::S_IDLE;
                            end
                        end
                        else
                        begin
                            node_next  = nx_q;
                            nx_re      = 1'b1;
                            nx_raddr   = nx_q;
                            vl_re      = 1'b1;
                            vl_raddr   = nx_q;
                            state_next = dllp_pkg::S_WALK2;
                        end
                    end
                    default:
                    begin
                        state_next = dllp_pkg::S_IDLE;
                    end
                endcase
            end

            dllp_pkg::S_LINK:
            begin
                if (can_emit)
                begin
                    nx_we = 1'b1;
                    pv_we = 1'b1;
                    nx_wdata = new_slot;
                    pv_wdata = new_slot;
                    if (op_reg == dllp_pkg::OP_INS_AFTER)
                    begin
                        nx_waddr = tgt_reg;
                        pv_waddr = nx_q;
                    end
                    else
                    begin
                        nx_waddr = pv_q;
                        pv_waddr = tgt_reg;
                    end
                    emit             = 1'b1;
                    emit_index       = alloc_count_reg[dllp_pkg::IDX_W-1:0];
                    alloc_count_next = new_slot;
                    state_next       = dllp_pkg::S_IDLE;
                end
            end

            dllp_pkg::S_WALK2:
            begin
                if (can_emit)
                begin
                    emit        = 1'b1;
                    emit_value  = vl_q;
                    emit_last   = (nx_q == '0);
                    cursor_next = (nx_q == '0) ? '0 : node_reg;
                    state_next  = dllp_pkg::S_IDLE;
                end
            end

            dllp_pkg::S_EMIT:
            begin
                if (can_emit)
                begin
                    emit        = 1'b1;
                    emit_status = err_reg;
                    state_next  = dllp_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = dllp_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = result_value_reg;
    assign rsp.new_index    = new_index_reg;
    assign rsp.walk_last    = walk_last_reg;
    assign rsp.list_empty   = list_empty_reg;
    assign rsp.status       = status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(alloc_count_reg) <= 32'(dllp_pkg::CAPACITY))
        else $error("pool count above capacity");

    a_cursor_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.opcode == dllp_pkg::OP_LOAD || req.opcode == dllp_pkg::OP_START ||
                    req.opcode == dllp_pkg::OP_REMOVE ||
                    req.opcode == dllp_pkg::OP_INS_AFTER ||
                    req.opcode == dllp_pkg::OP_INS_BEFORE))
        |=> (cursor_reg == '0))
        else $error("walk cursor not reset by a non-walk request");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != dllp_pkg::ST_OK)
        |-> (result_value_reg == '0 && new_index_reg == '0 &&
             !walk_last_reg && !list_empty_reg))
        else $error("error response carries data");

    a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(walk_last_reg && list_empty_reg))
        else $error("walk_last and list_empty both set");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || rsp.ready))
        else $error("response register overwritten while pending");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for doubly_linked_list_pool: directed and random requests
// checked against a behavioral list model. Needs dllp_pkg, dllp_if.sv and the top level.
module tb;
    import dllp_pkg::*;

    localparam int STALL_LIMIT = 1000;   // cycles with no handshake on either channel
    localparam int WORK_TARGET = 800;    // requests that do something, then stop
    localparam int LINK_SPAN   = 1 << LINK_W;

    typedef struct {
        logic [OPCODE_W-1:0]      opcode;
        logic signed [LINK_W-1:0] index;
        logic signed [DATA_W-1:0] value;
        logic signed [LINK_W-1:0] next_link;
        logic signed [LINK_W-1:0] prev_link;
        logic [COUNT_W-1:0]       node_count;
    } pool_req_t;

    typedef struct {
        logic signed [DATA_W-1:0] result_value;
        logic [IDX_W-1:0]         new_index;
        logic                     walk_last;
        logic                     list_empty;
        logic [STATUS_W-1:0]      status;
    } pool_rsp_t;

    // Behavioral model of the pool plus the queue of responses still owed.
    // Written flags track which pool entries hold defined data.
    class list_pool_scoreboard;
        logic [DATA_W-1:0] node_val [SLOTS];
        slot_t             succ [SLOTS];
        slot_t             pred [SLOTS];
        bit                has_val [SLOTS];
        bit                has_succ [SLOTS];
        bit                has_pred [SLOTS];
        int                alloc_count = 0;
        slot_t             cursor = '0;
        pool_rsp_t         pending[$];
        int                errors = 0;

        static function slot_t slot_of(logic signed [LINK_W-1:0] raw);
            int s;
            s = raw;
            if (s >= -1 && s < CAPACITY)
                return slot_t'(s + 1);
            return '0;
        endfunction

        // True when the request only reads entries that were written.
        function bit reads_defined(pool_req_t r);
            slot_t t;
            slot_t n;
            t = slot_of(r.index);
            case (r.opcode)
                OP_REMOVE:
                    return t == 0 || (has_val[t] && has_succ[t] && has_pred[t]);
                OP_INS_AFTER:
                    return alloc_count >= CAPACITY || has_succ[t];
                OP_INS_BEFORE:
                    return alloc_count >= CAPACITY || has_pred[t];
                OP_WALK:
                begin
                    if (!has_succ[cursor])
                        return 1'b0;
                    n = succ[cursor];
                    return n == 0 || (has_succ[n] && has_val[n]);
                end
                default:
                    return 1'b1;
            endcase
        endfunction

        function void note_request(pool_req_t r);
            slot_t     t;
            slot_t     ns;
            slot_t     nb;
            slot_t     pb;
            pool_rsp_t e;
            t = slot_of(r.index);
            e = '{default: '0};
            if (r.opcode > OP_WALK)
                return;
            if (r.opcode != OP_WALK)
                cursor = '0;
            case (r.opcode)
                OP_LOAD:
                begin
                    if (t != 0)
                    begin
                        node_val[t] = r.value;
                        succ[t]     = slot_of(r.next_link);
                        pred[t]     = slot_of(r.prev_link);
                        has_val[t]  = 1'b1;
                        has_succ[t] = 1'b1;
                        has_pred[t] = 1'b1;
                    end
                end
                OP_START:
                begin
                    succ[0]     = slot_of(r.next_link);
                    pred[0]     = slot_of(r.prev_link);
                    has_succ[0] = 1'b1;
                    has_pred[0] = 1'b1;
                    alloc_count = (r.node_count > CAPACITY) ? CAPACITY : int'(r.node_count);
                end
                OP_REMOVE:
                begin
                    if (t == 0)
                        e.status = ST_SENTINEL;
                    else
                    begin
                        nb = succ[t];
                        pb = pred[t];
                        pred[nb] = pb;
                        succ[pb] = nb;
                        has_pred[nb] = 1'b1;
                        has_succ[pb] = 1'b1;
                        e.result_value = node_val[t];
                    end
                    pending.push_back(e);
                end
                OP_INS_AFTER, OP_INS_BEFORE:
                begin
                    if (alloc_count >= CAPACITY)
                        e.status = ST_FULL;
                    else
                    begin
                        ns = slot_t'(alloc_count + 1);
                        node_val[ns] = r.value;
                        has_val[ns]  = 1'b1;
                        if (r.opcode == OP_INS_AFTER)
                        begin
                            nb = succ[t];
                            succ[ns] = nb;
                            pred[ns] = t;
                            pred[nb] = ns;
                            succ[t]  = ns;
                            has_pred[nb] = 1'b1;
                            has_succ[t]  = 1'b1;
                        end
                        else
                        begin
                            pb = pred[t];
                            succ[ns] = t;
                            pred[ns] = pb;
                            succ[pb] = ns;
                            pred[t]  = ns;
                            has_succ[pb] = 1'b1;
                            has_pred[t]  = 1'b1;
                        end
                        has_succ[ns] = 1'b1;
                        has_pred[ns] = 1'b1;
                        e.new_index = IDX_W'(alloc_count);
                        alloc_count = ns;
                    end
                    pending.push_back(e);
                end
                default:
                begin
                    nb = succ[cursor];
                    if (nb == 0)
                    begin
                        cursor = '0;
                        e.list_empty = 1'b1;
                    end
                    else
                    begin
                        e.walk_last    = (succ[nb] == 0);
                        cursor         = e.walk_last ? slot_t'(0) : nb;
                        e.result_value = node_val[nb];
                    end
                    pending.push_back(e);
                end
            endcase
        endfunction

        function void check_response(pool_rsp_t got);
            pool_rsp_t e;
            if (pending.size() == 0)
            begin
                $error("response with none outstanding: value %0d status %0d",
                       got.result_value, got.status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.result_value !== e.result_value)
            begin
                $error("result_value: expected %0d, got %0d", e.result_value, got.result_value);
                errors++;
            end
            if (got.new_index !== e.new_index)
            begin
                $error("new_index: expected %0d, got %0d", e.new_index, got.new_index);
                errors++;
            end
            if (got.walk_last !== e.walk_last)
            begin
                $error("walk_last: expected %0d, got %0d", e.walk_last, got.walk_last);
                errors++;
            end
            if (got.list_empty !== e.list_empty)
            begin
                $error("list_empty: expected %0d, got %0d", e.list_empty, got.list_empty);
                errors++;
            end
            if (got.status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    dllp_req_if req();
    dllp_rsp_if rsp();

    doubly_linked_list_pool i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    list_pool_scoreboard sb;
    int burst_left = 0;   // requests left in the current sender burst
    int work_items = 0;   // accepted requests that are not simply ignored
    int idle_cycles = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic pool_req_t mk(logic [OPCODE_W-1:0] op, int idx, logic [DATA_W-1:0] val,
                                     int nxt, int prv, int cnt);
        pool_req_t r;
        r.opcode     = op;
        r.index      = LINK_W'(idx);
        r.value      = val;
        r.next_link  = LINK_W'(nxt);
        r.prev_link  = LINK_W'(prv);
        r.node_count = COUNT_W'(cnt);
        return r;
    endfunction

    // List end: mostly -1, sometimes an out-of-range negative that also means the sentinel.
    function automatic int end_link();
        if ($urandom_range(0, 3) == 0)
            return -int'($urandom_range(2, 1024));
        return -1;
    endfunction

    function automatic void shuffle(ref int q[$]);
        int j;
        int tmp;
        for (int i = q.size() - 1; i > 0; i--)
        begin
            j    = $urandom_range(0, i);
            tmp  = q[i];
            q[i] = q[j];
            q[j] = tmp;
        end
    endfunction

    // Drive one request. The sender runs in bursts; a gap of idle cycles may open
    // before a new burst. The request is noted in the model on the accepting edge.
    task automatic send(input pool_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req.valid      <= 1'b1;
        req.opcode     <= r.opcode;
        req.index      <= r.index;
        req.value      <= r.value;
        req.next_link  <= r.next_link;
        req.prev_link  <= r.prev_link;
        req.node_count <= r.node_count;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        sb.note_request(r);
        if (!(r.opcode > OP_WALK || (r.opcode == OP_LOAD && sb.slot_of(r.index) == 0)))
            work_items++;
    endtask

    // Requests that would read never-written pool entries are dropped here.
    task automatic try_send(input pool_req_t r, output bit sent);
        sent = sb.reads_defined(r);
        if (sent)
            send(r);
    endtask

    // Builds a proper list (start plus one load per node, in random order), then
    // mixes walks, inserts and removes that keep it proper, with a few sentinel
    // removes and unknown opcodes thrown in.
    task automatic list_segment();
        int        k;
        int        c;
        int        lim;
        int        p;
        int        pick;
        int        tgt;
        int        fresh;
        bit        dup;
        bit        sent;
        bit        start_first;
        int        nodes[$];
        int        order[$];
        pool_req_t start_req;
        k = $urandom_range(0, 8);
        case ($urandom_range(0, 9))
            0:       c = $urandom_range(1016, LINK_SPAN - 1);   // near full or saturating
            1, 2:    c = $urandom_range(k, CAPACITY);
            default: c = k;
        endcase
        lim = (c > CAPACITY) ? CAPACITY : c;
        if (c == k)
        begin
            for (int i = 0; i < k; i++)
                nodes.push_back(i);
            shuffle(nodes);
        end
        else
        begin
            while (nodes.size() < k)
            begin
                pick = $urandom_range(0, lim - 1);
                dup  = 1'b0;
                foreach (nodes[i])
                    if (nodes[i] == pick)
                        dup = 1'b1;
                if (!dup)
                    nodes.push_back(pick);
            end
        end
        for (int i = 0; i < k; i++)
            order.push_back(i);
        shuffle(order);

        start_req = mk(OP_START, $urandom_range(0, LINK_SPAN - 1), $urandom,
                       (k != 0) ? nodes[0] : end_link(),
                       (k != 0) ? nodes[k-1] : end_link(), c);
        start_first = 1'($urandom_range(0, 1));
        if (start_first)
            send(start_req);
        foreach (order[j])
        begin
            p = order[j];
            send(mk(OP_LOAD, nodes[p], $urandom,
                    (p == k - 1) ? end_link() : nodes[p+1],
                    (p == 0) ? end_link() : nodes[p-1],
                    $urandom_range(0, LINK_SPAN - 1)));
        end
        if (!start_first)
            send(start_req);

        repeat ($urandom_range(6, 24))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                // walk runs, often to the end of the list and past it
                repeat ($urandom_range(1, nodes.size() + 2))
                    try_send(mk(OP_WALK, $urandom_range(0, LINK_SPAN - 1), $urandom,
                                $urandom_range(0, LINK_SPAN - 1),
                                $urandom_range(0, LINK_SPAN - 1),
                                $urandom_range(0, LINK_SPAN - 1)), sent);
            end
            else if (pick < 60)
            begin
                tgt = (nodes.size() == 0 || $urandom_range(0, 4) == 0) ? end_link()
                      : nodes[$urandom_range(0, nodes.size() - 1)];
                fresh = sb.alloc_count;
                try_send(mk($urandom_range(0, 1) ? OP_INS_AFTER : OP_INS_BEFORE, tgt, $urandom,
                            $urandom_range(0, LINK_SPAN - 1), $urandom_range(0, LINK_SPAN - 1),
                            $urandom_range(0, LINK_SPAN - 1)), sent);
                if (sent && fresh < CAPACITY)
                    nodes.push_back(fresh);
            end
            else if (pick < 80 && nodes.size() != 0)
            begin
                p = $urandom_range(0, nodes.size() - 1);
                try_send(mk(OP_REMOVE, nodes[p], $urandom, $urandom_range(0, LINK_SPAN - 1),
                            $urandom_range(0, LINK_SPAN - 1),
                            $urandom_range(0, LINK_SPAN - 1)), sent);
                if (sent)
                    nodes.delete(p);
            end
            else if (pick < 90)
                send(mk(OP_REMOVE, end_link(), $urandom, $urandom_range(0, LINK_SPAN - 1),
                        $urandom_range(0, LINK_SPAN - 1), $urandom_range(0, LINK_SPAN - 1)));
            else
                send(mk(OPCODE_W'($urandom_range(6, 7)), $urandom_range(0, LINK_SPAN - 1),
                        $urandom,
                        $urandom_range(0, LINK_SPAN - 1), $urandom_range(0, LINK_SPAN - 1),
                        $urandom_range(0, LINK_SPAN - 1)));
        end
    endtask

    // Unstructured requests; anything that would read undefined entries is skipped.
    task automatic noise_segment();
        bit sent;
        repeat ($urandom_range(3, 12))
            try_send(mk(OPCODE_W'($urandom_range(0, 7)),
                        $urandom_range(0, 1) ? $urandom_range(0, 16) - 1
                                             : $urandom_range(0, LINK_SPAN - 1),
                        $urandom,
                        $urandom_range(0, 1) ? $urandom_range(0, 16) - 1
                                             : $urandom_range(0, LINK_SPAN - 1),
                        $urandom_range(0, 1) ? $urandom_range(0, 16) - 1
                                             : $urandom_range(0, LINK_SPAN - 1),
                        $urandom_range(0, 1) ? $urandom_range(0, 20)
                                             : $urandom_range(0, LINK_SPAN - 1)), sent);
    endtask

    // Response sink: phases of always-ready, random ready, and long stalls with
    // short ready windows.
    initial
    begin : rsp_stall
        int mode;
        int phase_left;
        int hold;
        bit level;
        mode       = 0;
        phase_left = 0;
        hold       = 0;
        level      = 1'b0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase_left == 0)
            begin
                mode       = $urandom_range(0, 2);
                phase_left = $urandom_range(20, 200);
            end
            phase_left--;
            case (mode)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if (hold == 0)
                    begin
                        level = !level;
                        hold  = level ? $urandom_range(1, 3) : $urandom_range(4, 16);
                    end
                    hold--;
                    rsp.ready <= level;
                end
            endcase
        end
    end

    // Responses are sampled on the edge, before any update of this step lands.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            sb.check_response('{rsp.result_value, rsp.new_index, rsp.walk_last,
                                rsp.list_empty, rsp.status});
    end

    // Watchdog: a run of cycles with no handshake on either side means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        sb = new;
        rst_n           = 1'b0;
        req.valid      <= 1'b0;
        req.opcode     <= '0;
        req.index      <= '0;
        req.value      <= '0;
        req.next_link  <= '0;
        req.prev_link  <= '0;
        req.node_count <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, build [2,0,1] from the ends and the middle, walk it
        // with an unknown opcode mid-walk (cursor kept), wrap past the end, then a
        // sentinel remove that restarts the walk.
        send(mk(OP_START, 0, 0, -1, -1, 0));
        send(mk(OP_WALK, 0, 0, 0, 0, 0));
        send(mk(OP_INS_AFTER, -1, 32'h7fff_ffff, 0, 0, 0));
        send(mk(OP_INS_BEFORE, -1, 32'h8000_0000, 0, 0, 0));
        send(mk(OP_INS_BEFORE, 0, 32'hffff_ffff, 0, 0, 0));
        send(mk(OP_WALK, 0, 0, 0, 0, 0));
        send(mk(OP_WALK, 0, 0, 0, 0, 0));
        send(mk(3'd7, -1, 32'hffff_ffff, -1, -1, LINK_SPAN - 1));
        send(mk(OP_WALK, 0, 0, 0, 0, 0));
        send(mk(OP_WALK, 0, 0, 0, 0, 0));
        send(mk(OP_REMOVE, -1, 0, 0, 0, 0));
        send(mk(OP_WALK, 0, 0, 0, 0, 0));
        // Most negative index is out of range, so it is the sentinel too.
        send(mk(OP_REMOVE, -1024, 0, 0, 0, 0));
        send(mk(OP_REMOVE, 0, 0, 0, 0, 0));
        // Load to the sentinel does nothing.
        send(mk(OP_LOAD, -1, 32'h0000_0001, 0, 0, 0));
        // Top index, count saturating to a full pool, insert refused.
        send(mk(OP_LOAD, CAPACITY - 1, 32'h5a5a_5a5a, -1, -1, 0));
        send(mk(OP_START, 0, 0, CAPACITY - 1, CAPACITY - 1, LINK_SPAN - 1));
        send(mk(OP_WALK, 0, 0, 0, 0, 0));
        send(mk(OP_INS_AFTER, CAPACITY - 1, 32'h1234_5678, 0, 0, 0));
        // Last free slot: the insert lands on its own target and forms a self loop.
        send(mk(OP_START, 0, 0, CAPACITY - 1, CAPACITY - 1, CAPACITY - 1));
        send(mk(OP_INS_BEFORE, CAPACITY - 1, 32'h0, 0, 0, 0));
        send(mk(OP_WALK, 0, 0, 0, 0, 0));
        send(mk(OP_WALK, 0, 0, 0, 0, 0));
        send(mk(OP_INS_AFTER, -1, 32'h1, 0, 0, 0));
        // Out-of-range links read as the sentinel.
        send(mk(OP_LOAD, 5, 32'd1234, -7, -1, 0));
        send(mk(OP_START, 0, 0, 5, -300, 0));
        send(mk(OP_WALK, 0, 0, 0, 0, 0));

        // Random: mostly well-formed lists, some unstructured traffic.
        while (work_items < WORK_TARGET)
        begin
            if ($urandom_range(0, 6) == 0)
                noise_segment();
            else
                list_segment();
        end
        req.valid <= 1'b0;

        // Drain, then allow a few extra cycles for any stray response.
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
